// ----- rtl/xo128_pkg.sv -----
// ----------------------------------------------------------------------------
// xo128_pkg
// Types, constants and step functions of the xoshiro128++ generator.
// ----------------------------------------------------------------------------
`default_nettype none

package xo128_pkg;

  typedef logic [3:0][31:0] gen_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_JUMP
  } fsm_state_t;

  localparam logic [2:0] OP_NEXT      = 3'd0;
  localparam logic [2:0] OP_JUMP      = 3'd1;
  localparam logic [2:0] OP_LONG_JUMP = 3'd2;
  localparam logic [2:0] OP_ABSORB    = 3'd3;
  localparam logic [2:0] OP_FINISH    = 3'd4;

  localparam logic [127:0] JUMP_POLY =
    128'h77f2db5b_6fa035c3_f542d2d3_8764000b;
  localparam logic [127:0] LONG_JUMP_POLY =
    128'h1c580662_ccf5a0ef_0b6f099f_b523952e;

  localparam logic [63:0] HASH_A_INIT = 64'h00000000deadbeef;
  localparam logic [63:0] HASH_B_INIT = 64'h0000000041c6ce57;
  localparam logic [63:0] ABSORB_K_A  = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] ABSORB_K_B  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] FINAL_K_A   = 64'hff51afd7ed558ccd;
  localparam logic [63:0] FINAL_K_B   = 64'hc4ceb9fe1a85ec53;

  function automatic logic [31:0] gen_word(input gen_state_t w);
    logic [31:0] s;
    s = w[0] + w[3];
    return {s[24:0], s[31:25]} + w[0];
  endfunction

  function automatic gen_state_t gen_advance(input gen_state_t w);
    gen_state_t  n;
    logic [31:0] t;
    t    = {w[1][22:0], 9'd0};
    n    = w;
    n[2] = n[2] ^ n[0];
    n[3] = n[3] ^ n[1];
    n[1] = n[1] ^ n[2];
    n[0] = n[0] ^ n[3];
    n[2] = n[2] ^ t;
    n[3] = {n[3][20:0], n[3][31:21]};
    return n;
  endfunction

  function automatic logic [63:0] hash_const(input logic finish, input logic sel_b);
    logic [63:0] k;
    if (finish) begin
      k = sel_b ? FINAL_K_B : FINAL_K_A;
    end else begin
      k = sel_b ? ABSORB_K_B : ABSORB_K_A;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/xoshiro128pp_generator.sv -----
// ----------------------------------------------------------------------------
// xoshiro128pp_generator
// xoshiro128++ generator with streamed two-hash seeding and polynomial jumps.
// ----------------------------------------------------------------------------
// Next: result beat registered in the cycle after accept; one word per cycle while out_tready holds.
// Absorb and finish: the two hashes, one after the other, on the shared 32x32 multiplier
//   (3 partial products plus accumulate for each of the two 64-bit hashes).
// Jump and long jump: one generator step per bit of the 128-bit polynomial.
// Reset: generator state zero, hashes at their initial values, no beat held.
// ----------------------------------------------------------------------------
`default_nettype none

module xoshiro128pp_generator (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [2:0] op, [10:3] seed_byte, [15:11] zero
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // [31:0] random_word
);
  import xo128_pkg::*;

  fsm_state_t  state_r, state_nxt;
  gen_state_t  w_r, w_nxt;
  gen_state_t  jacc_r, jacc_nxt;
  logic [63:0] ha_r, ha_nxt;
  logic [63:0] hb_r, hb_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] macc_r, macc_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [6:0]  idx_r, idx_nxt;
  logic [1:0]  mstep_r, mstep_nxt;
  logic        fin_r, fin_nxt;
  logic        hsel_r, hsel_nxt;
  logic        lsel_r, lsel_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_data_r, out_data_nxt;

  logic        in_accept;
  logic [2:0]  in_op;
  logic [63:0] hsrc, xop, kop, hfin, fval;
  logic [31:0] mul_a, mul_b;
  logic        pbit;
  gen_state_t  jacc_x;

  assign in_op      = in_tdata[2:0];
  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    hsrc = hsel_r ? hb_r : ha_r;
    xop  = fin_r ? (hsrc ^ (hsrc >> 33)) : (hsrc ^ {56'd0, byte_r});
    kop  = hash_const(fin_r, hsel_r);
    unique case (mstep_r)
      2'd0:    begin mul_a = xop[31:0];  mul_b = kop[31:0];  end
      2'd1:    begin mul_a = xop[31:0];  mul_b = kop[63:32]; end
      default: begin mul_a = xop[63:32]; mul_b = kop[31:0];  end
    endcase
    hfin   = {macc_r[63:32] + prod_r[31:0], macc_r[31:0]};
    fval   = hfin ^ (hfin >> 33);
    pbit   = lsel_r ? LONG_JUMP_POLY[idx_r] : JUMP_POLY[idx_r];
    jacc_x = jacc_r ^ (pbit ? w_r : '0);
  end

  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    jacc_nxt      = jacc_r;
    ha_nxt        = ha_r;
    hb_nxt        = hb_r;
    prod_nxt      = prod_r;
    macc_nxt      = macc_r;
    byte_nxt      = byte_r;
    idx_nxt       = idx_r;
    mstep_nxt     = mstep_r;
    fin_nxt       = fin_r;
    hsel_nxt      = hsel_r;
    lsel_nxt      = lsel_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (in_op)
            OP_NEXT: begin
              out_data_nxt  = gen_word(w_r);
              out_valid_nxt = 1'b1;
              w_nxt         = gen_advance(w_r);
            end
            OP_JUMP, OP_LONG_JUMP: begin
              lsel_nxt  = (in_op == OP_LONG_JUMP);
              idx_nxt   = '0;
              jacc_nxt  = '0;
              state_nxt = ST_JUMP;
            end
            OP_ABSORB, OP_FINISH: begin
              fin_nxt   = (in_op == OP_FINISH);
              byte_nxt  = in_tdata[10:3];
              hsel_nxt  = 1'b0;
              mstep_nxt = '0;
              state_nxt = ST_MUL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_JUMP: begin
        jacc_nxt = jacc_x;
        w_nxt    = gen_advance(w_r);
        idx_nxt  = idx_r + 7'd1;
        if (idx_r == 7'd127) begin
          w_nxt     = jacc_x;
          state_nxt = ST_IDLE;
        end
      end
      ST_MUL: begin
        prod_nxt  = mul_a * mul_b;
        mstep_nxt = mstep_r + 2'd1;
        unique case (mstep_r)
          2'd0: begin
          end
          2'd1: macc_nxt = prod_r;
          2'd2: macc_nxt = hfin;
          default: begin
            if (fin_r) begin
              if (hsel_r) begin
                w_nxt[3] = fval[63:32];
                w_nxt[2] = fval[31:0];
                hb_nxt   = HASH_B_INIT;
              end else begin
                w_nxt[1] = fval[63:32];
                w_nxt[0] = fval[31:0];
                ha_nxt   = HASH_A_INIT;
              end
            end else if (hsel_r) begin
              hb_nxt = hfin;
            end else begin
              ha_nxt = hfin;
            end
            if (hsel_r) begin
              state_nxt = ST_IDLE;
            end else begin
              hsel_nxt = 1'b1;
            end
          end
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      w_r         <= '0;
      ha_r        <= HASH_A_INIT;
      hb_r        <= HASH_B_INIT;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      w_r         <= w_nxt;
      ha_r        <= ha_nxt;
      hb_r        <= hb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    jacc_r     <= jacc_nxt;
    prod_r     <= prod_nxt;
    macc_r     <= macc_nxt;
    byte_r     <= byte_nxt;
    idx_r      <= idx_nxt;
    mstep_r    <= mstep_nxt;
    fin_r      <= fin_nxt;
    hsel_r     <= hsel_nxt;
    lsel_r     <= lsel_nxt;
    out_data_r <= out_data_nxt;
  end

  a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready)
    else $error("input ready while a multi-cycle op runs");

  a_next_gives_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_NEXT) |=> out_valid_r)
    else $error("next op produced no result beat");

  a_jump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_JUMP && idx_r == 7'd127) |=> (state_r == ST_IDLE))
    else $error("jump did not end after the last polynomial bit");

  a_mul_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL && mstep_r == 2'd3 && hsel_r) |=> (state_r == ST_IDLE))
    else $error("hash sequence did not end after the second hash");

endmodule

`default_nettype wire
